### rtl/trigram_document_index_macros.svh
// Assertion macros for the trigram document index.
// Uses the clk_i and rst_ni names of the including module.
`ifndef TRIGRAM_DOCUMENT_INDEX_MACROS_SVH
`define TRIGRAM_DOCUMENT_INDEX_MACROS_SVH

// Checked after reset is released.
`define TDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, also while reset is asserted.
`define TDI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/tdi_pkg.sv
// Shared constants and codes for the trigram document index.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdi_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF  = 1024;
  localparam int unsigned DOCS_PER_ENTRY_DEF = 8;
  localparam int unsigned TOKEN_BITS_DEF     = 20;
  localparam int unsigned DOC_BITS_DEF       = 10;

  // a match under unique_only needs a list of exactly this many documents
  localparam int unsigned PAIR_SIZE = 2;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_MATCH    = 2'd1,
    FUNC_TEMPLATE = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIQUE_ONLY     = 1'd0,
    CFG_IGNORE_TEMPLATE = 1'd1
  } cfg_idx_e;

endpackage

`default_nettype wire

### rtl/tdi_req_if.sv
// Request channel of the trigram document index: valid/ready plus one item.
// Depends on tdi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdi_req_if #(
  parameter int unsigned TOKEN_BITS = tdi_pkg::TOKEN_BITS_DEF,
  parameter int unsigned DOC_BITS   = tdi_pkg::DOC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [tdi_pkg::FUNC_W-1:0]  func;
  logic [TOKEN_BITS-1:0]       token_first;
  logic [TOKEN_BITS-1:0]       token_second;
  logic [TOKEN_BITS-1:0]       token_third;
  logic [DOC_BITS-1:0]         document;
  logic [DOC_BITS-1:0]         other_document;
  logic                        mark_template;

  modport source (
    output valid, func, token_first, token_second, token_third,
           document, other_document, mark_template,
    input  ready
  );
  modport sink (
    input  valid, func, token_first, token_second, token_third,
           document, other_document, mark_template,
    output ready
  );
endinterface

`default_nettype wire

### rtl/tdi_rsp_if.sv
// Result channel of the trigram document index: valid/ready plus four flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tdi_rsp_if;
  logic valid;
  logic ready;
  logic added;
  logic matched;
  logic template_flag;
  logic overflow;

  modport source (output valid, added, matched, template_flag, overflow, input ready);
  modport sink   (input  valid, added, matched, template_flag, overflow, output ready);
endinterface

`default_nettype wire

### rtl/tdi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tdi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/trigram_document_index.sv
// Trigram document index. Each item runs hash, the probe loop (RAM read, slot check), the
// document scan when an entry is found or claimed, then the decide step that posts the
// result; a clear transfer sweeps the entry RAM. One item at a time; the next is taken
// while a result still waits. Rate is set by the entry RAM probe loop and the doc scan.
// Reset: config regs to 0, then a sweep clears the entry RAM, ready low.
`timescale 1ns / 1ps
`default_nettype none

module trigram_document_index #(
  parameter int unsigned TABLE_ENTRIES  = tdi_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned DOCS_PER_ENTRY = tdi_pkg::DOCS_PER_ENTRY_DEF,
  parameter int unsigned TOKEN_BITS     = tdi_pkg::TOKEN_BITS_DEF,
  parameter int unsigned DOC_BITS       = tdi_pkg::DOC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tdi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tdi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  tdi_req_if.sink                         req_i,
  tdi_rsp_if.source                       rsp_o
);

  // ---------------------------------------------------------------------------
  // Sizes
  // ---------------------------------------------------------------------------
  localparam int unsigned KEY_W     = 3 * TOKEN_BITS;
  localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int unsigned PCNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CNT_W     = $clog2(DOCS_PER_ENTRY + 1);
  localparam int unsigned DOC_DEPTH = TABLE_ENTRIES * DOCS_PER_ENTRY;
  localparam int unsigned DOC_AW    = $clog2(DOC_DEPTH);
  // entry word: {valid, key, template, doc count}
  localparam int unsigned ENT_W     = KEY_W + CNT_W + 2;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]    TABLE_X    = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  DOCS_FULL  = CNT_W'(DOCS_PER_ENTRY);
  localparam logic [CNT_W-1:0]  PAIR_CNT   = CNT_W'(tdi_pkg::PAIR_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE,   // ready for a transfer
    ST_HASH,   // fold key into a home slot
    ST_PRD,    // entry RAM read in flight
    ST_PCHK,   // check probed slot
    ST_SCAN,   // walk the document list
    ST_FIN,    // decide, write back, post result
    ST_CLEAR   // sweep entry RAM valid bits
  } state_e;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic unique_q;
  logic ignore_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unique_q <= 1'b0;
      ignore_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (tdi_pkg::cfg_idx_e'(cfg_index_i))
        tdi_pkg::CFG_UNIQUE_ONLY:     unique_q <= cfg_data_i[0];
        tdi_pkg::CFG_IGNORE_TEMPLATE: ignore_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture (payload, no reset)
  // ---------------------------------------------------------------------------
  state_e               state_q;
  tdi_pkg::func_e       func_q;
  logic [KEY_W-1:0]     key_q;
  logic [DOC_BITS-1:0]  doc_q;
  logic [DOC_BITS-1:0]  other_q;
  logic                 mark_q;
  logic                 req_xfer;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      func_q  <= tdi_pkg::func_e'(req_i.func);
      key_q   <= {req_i.token_first, req_i.token_second, req_i.token_third};
      doc_q   <= req_i.document;
      other_q <= req_i.other_document;
      mark_q  <= req_i.mark_template;
    end
  end

  // ---------------------------------------------------------------------------
  // Home slot: XOR-fold of the key, then one conditional subtract so the slot
  // stays below TABLE_ENTRIES when that is not a power of two.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] fold;
  logic [IDX_W:0]   fold_x;
  logic [IDX_W-1:0] home;

  always_comb begin
    fold = '0;
    for (int b = 0; b < KEY_W; b++) begin
      fold[b % IDX_W] = fold[b % IDX_W] ^ key_q[b];
    end
  end

  assign fold_x = {1'b0, fold};
  assign home   = (fold_x >= TABLE_X) ? IDX_W'(fold_x - TABLE_X) : fold;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  probe_q;    // slot being probed / found slot
  logic [PCNT_W-1:0] pcnt_q;     // probes done so far
  logic [IDX_W-1:0]  clr_q;      // sweep pointer
  logic              clr_item_q; // sweep came from a clear transfer
  logic              found_q;    // entry exists or was just claimed
  logic              tmpl_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DOC_AW-1:0] base_q;     // first doc slot of the entry
  logic [CNT_W-1:0]  k_q;        // next doc read
  logic              pend_q;     // doc read data arrives this cycle
  logic              hit_a_q;
  logic              hit_b_q;
  logic              out_vld_q;
  logic              out_added_q;
  logic              out_matched_q;
  logic              out_tflag_q;
  logic              out_overflow_q;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  logic [ENT_W-1:0] ent_wdata;
  logic [ENT_W-1:0] ent_rdata;

  logic              doc_we;
  logic [DOC_AW-1:0] doc_waddr;
  logic [DOC_AW-1:0] doc_raddr;
  logic [DOC_BITS-1:0] doc_rdata;

  tdi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (probe_q),
    .rdata_o (ent_rdata)
  );

  tdi_ram #(
    .WIDTH (DOC_BITS),
    .DEPTH (DOC_DEPTH)
  ) u_doc_ram (
    .clk_i   (clk_i),
    .we_i    (doc_we),
    .waddr_i (doc_waddr),
    .wdata_i (doc_q),
    .raddr_i (doc_raddr),
    .rdata_o (doc_rdata)
  );

  logic             rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic             rd_tmpl;
  logic [CNT_W-1:0] rd_cnt;
  logic [DOC_AW-1:0] probe_base;

  assign rd_valid   = ent_rdata[ENT_W-1];
  assign rd_key     = ent_rdata[ENT_W-2 -: KEY_W];
  assign rd_tmpl    = ent_rdata[CNT_W];
  assign rd_cnt     = ent_rdata[CNT_W-1:0];
  assign probe_base = DOC_AW'(DOC_AW'(probe_q) * DOC_AW'(DOCS_PER_ENTRY));

  assign doc_raddr = base_q + DOC_AW'(k_q);
  assign doc_waddr = base_q + DOC_AW'(cnt_q);

  // ---------------------------------------------------------------------------
  // Final decision for the item in ST_FIN
  // ---------------------------------------------------------------------------
  logic             fin_go;
  logic             is_ins;
  logic             ins_add;
  logic             ins_ovf;
  logic             tmpl_new;
  logic [CNT_W-1:0] cnt_new;
  logic             match_ok;

  assign fin_go   = (state_q == ST_FIN) && (!out_vld_q || rsp_o.ready);
  assign is_ins   = (func_q == tdi_pkg::FUNC_INSERT);
  // table full on a new key, or list full on a new document
  assign ins_ovf  = !found_q || (!hit_a_q && (cnt_q == DOCS_FULL));
  assign ins_add  = found_q && !hit_a_q && (cnt_q != DOCS_FULL);
  assign tmpl_new = tmpl_q | mark_q;
  assign cnt_new  = ins_add ? cnt_q + CNT_W'(1) : cnt_q;
  assign match_ok = found_q && hit_a_q && hit_b_q
                    && !(ignore_q && tmpl_q)
                    && !(unique_q && (cnt_q != PAIR_CNT));

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = probe_q;
    ent_wdata = {1'b1, key_q, tmpl_new, cnt_new};
    if (state_q == ST_CLEAR) begin
      ent_we    = 1'b1;
      ent_waddr = clr_q;
      ent_wdata = '0;
    end else if (fin_go && is_ins && !ins_ovf) begin
      // covers a freshly claimed entry, a new doc and a template-only update
      ent_we = 1'b1;
    end
  end

  assign doc_we = fin_go && is_ins && ins_add;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      probe_q        <= '0;
      pcnt_q         <= '0;
      clr_q          <= '0;
      clr_item_q     <= 1'b0;
      found_q        <= 1'b0;
      tmpl_q         <= 1'b0;
      cnt_q          <= '0;
      base_q         <= '0;
      k_q            <= '0;
      pend_q         <= 1'b0;
      hit_a_q        <= 1'b0;
      hit_b_q        <= 1'b0;
      out_vld_q      <= 1'b0;
      out_added_q    <= 1'b0;
      out_matched_q  <= 1'b0;
      out_tflag_q    <= 1'b0;
      out_overflow_q <= 1'b0;
    end else begin
      // a result posted in this cycle replaces the one leaving
      if (out_vld_q && rsp_o.ready && !fin_go) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_xfer) begin
            if (tdi_pkg::func_e'(req_i.func) == tdi_pkg::FUNC_CLEAR) begin
              clr_q      <= '0;
              clr_item_q <= 1'b1;
              state_q    <= ST_CLEAR;
            end else begin
              state_q <= ST_HASH;
            end
          end
        end

        ST_HASH: begin
          probe_q <= home;
          pcnt_q  <= '0;
          state_q <= ST_PRD;
        end

        ST_PRD: begin
          state_q <= ST_PCHK;
        end

        ST_PCHK: begin
          k_q     <= '0;
          pend_q  <= 1'b0;
          hit_a_q <= 1'b0;
          hit_b_q <= 1'b0;
          base_q  <= probe_base;
          if (!rd_valid) begin
            // empty slot ends the chain: key absent
            tmpl_q  <= 1'b0;
            cnt_q   <= '0;
            found_q <= is_ins;
            state_q <= is_ins ? ST_SCAN : ST_FIN;
          end else if (rd_key == key_q) begin
            found_q <= 1'b1;
            tmpl_q  <= rd_tmpl;
            cnt_q   <= rd_cnt;
            state_q <= ST_SCAN;
          end else if (pcnt_q == LAST_PROBE) begin
            // every slot taken by another key
            found_q <= 1'b0;
            tmpl_q  <= 1'b0;
            cnt_q   <= '0;
            state_q <= ST_FIN;
          end else begin
            probe_q <= (probe_q == LAST_IDX) ? '0 : probe_q + IDX_W'(1);
            pcnt_q  <= pcnt_q + PCNT_W'(1);
            state_q <= ST_PRD;
          end
        end

        ST_SCAN: begin
          // one read issued per cycle, compared in the cycle after
          if (pend_q) begin
            if (doc_rdata == doc_q) begin
              hit_a_q <= 1'b1;
            end
            if (doc_rdata == other_q) begin
              hit_b_q <= 1'b1;
            end
          end
          if (k_q != cnt_q) begin
            k_q    <= k_q + CNT_W'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= ST_FIN;
            end
          end
        end

        ST_FIN: begin
          if (fin_go) begin
            out_vld_q      <= 1'b1;
            out_added_q    <= is_ins && ins_add;
            out_overflow_q <= is_ins && ins_ovf;
            out_matched_q  <= (func_q == tdi_pkg::FUNC_MATCH) && match_ok;
            out_tflag_q    <= (func_q == tdi_pkg::FUNC_TEMPLATE) && tmpl_q;
            clr_item_q     <= 1'b0;
            state_q        <= ST_IDLE;
          end
        end

        ST_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == LAST_IDX) begin
            // a clear transfer reports an all-zero result; the reset sweep does not
            state_q <= clr_item_q ? ST_FIN : ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.added         = out_added_q;
  assign rsp_o.matched       = out_matched_q;
  assign rsp_o.template_flag = out_tflag_q;
  assign rsp_o.overflow      = out_overflow_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "trigram_document_index_macros.svh"

  `TDI_ASSERT_ALWAYS(a_add_ovf_excl, !(out_added_q && out_overflow_q), "added and overflow both set")
  `TDI_ASSERT(a_doc_wr_room, doc_we |-> (found_q && (cnt_q != DOCS_FULL)), "doc write into full list")
  `TDI_ASSERT(a_rsp_from_fin, $rose(out_vld_q) |-> ($past(state_q) == ST_FIN), "result not from decide")
  `TDI_ASSERT(a_clear_ends, ((state_q == ST_CLEAR) && (clr_q == LAST_IDX)) |=> (state_q != ST_CLEAR), "sweep overran")

endmodule

`default_nettype wire
